@@ rtl/core/ultrasonic_range_to_seven_segment_macros.svh @@
// Assertion helpers used by the checker file of this block.
`ifndef ULTRASONIC_RANGE_TO_SEVEN_SEGMENT_MACROS_SVH
`define ULTRASONIC_RANGE_TO_SEVEN_SEGMENT_MACROS_SVH

// Clocked property with an active-low asynchronous reset as the disable term.
`define URSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define URSS_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

@@ rtl/core/urss_pkg.sv @@
package urss_pkg;

  // Field widths.
  localparam int unsigned EchoW   = 16;
  localparam int unsigned DistW   = 14;
  localparam int unsigned SegW    = 7;
  localparam int unsigned InDataW = 16;
  // Distance, four segment fields, alarm and no-echo, padded to whole bytes.
  localparam int unsigned OutUsedW = DistW + 4 * SegW + 2;
  localparam int unsigned OutDataW = ((OutUsedW + 7) / 8) * 8;

  // Register indexes of the configuration port.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegAlarmThreshold = 1'd0;
  localparam logic [CfgIdxW-1:0] RegEchoTimeout    = 1'd1;
  localparam int unsigned CfgDataW = 16;

  // Reset values of the registers.
  localparam logic [DistW-1:0] ThreshReset  = 14'd200;
  localparam logic [EchoW-1:0] TimeoutReset = 16'd30000;

  // Speed of sound scaling: mm = us * 343 / 2000.
  localparam int unsigned SoundNum = 343;
  localparam int unsigned ProdW    = 25;  // 65535 * 343 fits in 25 bits
  // 2000 = 16 * 125; the divide by 125 is a multiply by ceil(2^28 / 125).
  localparam int unsigned Div16Sh  = 4;
  localparam int unsigned QW       = ProdW - Div16Sh;  // 21 bits
  localparam int unsigned RecipSh  = 28;
  localparam int unsigned RecipW   = 22;
  localparam logic [RecipW-1:0] Recip125 = 22'd2147484;
  localparam int unsigned RecProdW = QW + RecipW;      // 43 bits
  localparam int unsigned QuoW     = RecProdW - RecipSh; // 15 bits

  localparam logic [DistW-1:0] DistMax = 14'd9999;

  // Decimal digit weights.
  localparam logic [DistW-1:0] Step1000 = 14'd1000;
  localparam logic [DistW-1:0] Step100  = 14'd100;
  localparam logic [DistW-1:0] Step10   = 14'd10;

  // Segment pattern of a nine, bit 0 = a.
  localparam logic [SegW-1:0] SegNine = 7'h6F;

  // Largest digit d in 0..9 with d * step <= v; the compares are independent.
  function automatic logic [3:0] dec_digit(logic [DistW-1:0] v, logic [DistW-1:0] step);
    logic [3:0] d;
    d = 4'd0;
    for (int i = 1; i < 10; i++) begin
      if (v >= DistW'(i) * step) begin
        d = 4'(i);
      end
    end
    return d;
  endfunction

  // Active-high seven-segment pattern of a decimal digit.
  function automatic logic [SegW-1:0] seg_of(logic [3:0] d);
    logic [SegW-1:0] s;
    case (d)
      4'd0: s = 7'h3F;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5B;
      4'd3: s = 7'h4F;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6D;
      4'd6: s = 7'h7D;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7F;
      4'd9: s = 7'h6F;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

@@ rtl/core/ultrasonic_range_to_seven_segment.sv @@
// Echo-width to distance and seven-segment converter. Each transaction on the
// slave stream carries one echo width in microseconds; each transaction on the
// master stream carries the distance in mm (width*343/2000, clamped to 9999,
// 9999 when the width is zero or above the timeout), the four digit patterns
// (active high, bit 0 = segment a), the alarm flag (distance at or below the
// threshold) and the no-echo flag. The block is a six-stage pipeline: it takes
// one item per clock while the master side does not stall, and each result
// moves through stages one to five and the output register onto the master stream.
// The whole pipeline advances together, so a stall on the master side holds every
// stage and deasserts s_axis_tready. The user writes registers through cfg_we_i /
// cfg_idx_i / cfg_wdata_i only while no transaction is in flight; no check enforces it.
module ultrasonic_range_to_seven_segment (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port.
  input  logic                               cfg_we_i,
  input  logic [urss_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [urss_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // Slave stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [urss_pkg::InDataW-1:0]       s_axis_tdata,  // [15:0] echo_us
  // Master stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [13:0] distance_mm, [20:14] seg_thousands, [27:21] seg_hundreds,
  // [34:28] seg_tens, [41:35] seg_ones, [42] alarm, [43] no_echo, [47:44] zero
  output logic [urss_pkg::OutDataW-1:0]      m_axis_tdata
);

  localparam int unsigned DistW = urss_pkg::DistW;
  localparam int unsigned SegW  = urss_pkg::SegW;

  // Configuration registers.
  logic [DistW-1:0]          thresh_q;
  logic [urss_pkg::EchoW-1:0] timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q  <= urss_pkg::ThreshReset;
      timeout_q <= urss_pkg::TimeoutReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        urss_pkg::RegAlarmThreshold: thresh_q  <= cfg_wdata_i[DistW-1:0];
        urss_pkg::RegEchoTimeout:    timeout_q <= cfg_wdata_i[urss_pkg::EchoW-1:0];
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output register is free.
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // Valid bits of stages one to five and of the output register.
  logic [4:0] vld_q;
  logic       out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[3:0], s_axis_tvalid};
      out_vld_q <= vld_q[4];
    end
  end

  // Stage 1: scale by 343 and flag a missing echo.
  logic [urss_pkg::EchoW-1:0] echo;
  logic [urss_pkg::ProdW-1:0] prod1_d, prod1_q;
  logic                       none1_d, none1_q;

  assign echo    = s_axis_tdata[urss_pkg::EchoW-1:0];
  assign prod1_d = urss_pkg::ProdW'(echo) * urss_pkg::ProdW'(urss_pkg::SoundNum);
  assign none1_d = (echo == '0) || (echo > timeout_q);

  // Stage 2: divide by 16 as a shift, then multiply by the reciprocal of 125.
  logic [urss_pkg::RecProdW-1:0] rec2_d, rec2_q;
  logic                          none2_q;

  assign rec2_d = urss_pkg::RecProdW'(prod1_q[urss_pkg::ProdW-1:urss_pkg::Div16Sh]) *
                  urss_pkg::RecProdW'(urss_pkg::Recip125);

  // Stage 3: take the quotient, clamp it and substitute the no-echo value.
  logic [urss_pkg::QuoW-1:0] quo;
  logic [DistW-1:0]          dist3_d, dist3_q;
  logic                      none3_q;

  assign quo = rec2_q[urss_pkg::RecProdW-1:urss_pkg::RecipSh];

  always_comb begin
    if (none2_q || (quo > urss_pkg::QuoW'(urss_pkg::DistMax))) begin
      dist3_d = urss_pkg::DistMax;
    end else begin
      dist3_d = quo[DistW-1:0];
    end
  end

  // Stage 4: thousands digit and alarm compare.
  logic [3:0]       th4_d, th4_q;
  logic [9:0]       rem4_d, rem4_q;
  logic [DistW-1:0] dist4_q;
  logic             alarm4_q, none4_q;
  logic [DistW-1:0] sub4;

  assign th4_d  = urss_pkg::dec_digit(dist3_q, urss_pkg::Step1000);
  assign sub4   = dist3_q - DistW'(th4_d) * urss_pkg::Step1000;
  assign rem4_d = sub4[9:0];

  // Stage 5: hundreds digit.
  logic [3:0]       h5_d, h5_q, th5_q;
  logic [6:0]       rem5_d, rem5_q;
  logic [DistW-1:0] dist5_q;
  logic             alarm5_q, none5_q;
  logic [DistW-1:0] sub5;

  assign h5_d   = urss_pkg::dec_digit(DistW'(rem4_q), urss_pkg::Step100);
  assign sub5   = DistW'(rem4_q) - DistW'(h5_d) * urss_pkg::Step100;
  assign rem5_d = sub5[6:0];

  // Stage 6 input: tens and ones digits.
  logic [3:0]       t6, o6;
  logic [DistW-1:0] sub6;

  assign t6   = urss_pkg::dec_digit(DistW'(rem5_q), urss_pkg::Step10);
  assign sub6 = DistW'(rem5_q) - DistW'(t6) * urss_pkg::Step10;
  assign o6   = sub6[3:0];

  // Output register fields.
  logic [DistW-1:0] out_dist_q;
  logic [SegW-1:0]  out_th_q, out_h_q, out_t_q, out_o_q;
  logic             out_alarm_q, out_none_q;

  // Payload registers of all stages; they move with the valid bits.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod1_q     <= prod1_d;
      none1_q     <= none1_d;
      rec2_q      <= rec2_d;
      none2_q     <= none1_q;
      dist3_q     <= dist3_d;
      none3_q     <= none2_q;
      th4_q       <= th4_d;
      rem4_q      <= rem4_d;
      dist4_q     <= dist3_q;
      alarm4_q    <= (dist3_q <= thresh_q);
      none4_q     <= none3_q;
      h5_q        <= h5_d;
      th5_q       <= th4_q;
      rem5_q      <= rem5_d;
      dist5_q     <= dist4_q;
      alarm5_q    <= alarm4_q;
      none5_q     <= none4_q;
      out_dist_q  <= dist5_q;
      out_th_q    <= urss_pkg::seg_of(th5_q);
      out_h_q     <= urss_pkg::seg_of(h5_q);
      out_t_q     <= urss_pkg::seg_of(t6);
      out_o_q     <= urss_pkg::seg_of(o6);
      out_alarm_q <= alarm5_q;
      out_none_q  <= none5_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = urss_pkg::OutDataW'({out_none_q, out_alarm_q, out_o_q, out_t_q,
                                              out_h_q, out_th_q, out_dist_q});

endmodule

@@ rtl/core/urss_checker.sv @@
`include "ultrasonic_range_to_seven_segment_macros.svh"

// Port-level checks of the range converter.
module urss_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [urss_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [urss_pkg::DistW-1:0] dist_mm;
  logic [urss_pkg::SegW-1:0]  seg_th, seg_o;
  logic                       no_echo;
  logic                       stalled;
  logic                       over_max;
  logic                       out_none;
  logic                       shows_nines;

  assign dist_mm = m_axis_tdata[13:0];
  assign seg_th  = m_axis_tdata[20:14];
  assign seg_o   = m_axis_tdata[41:35];
  assign no_echo = m_axis_tdata[43];

  // Shorthands for the checks below.
  assign stalled     = m_axis_tvalid && !m_axis_tready;
  assign over_max    = dist_mm > urss_pkg::DistMax;
  assign out_none    = m_axis_tvalid && no_echo;
  assign shows_nines = (dist_mm == urss_pkg::DistMax) && (seg_th == urss_pkg::SegNine) &&
                       (seg_o == urss_pkg::SegNine);

  // A held result keeps its data until the transaction completes.
  `URSS_ASSERT(a_hold_data, clk_i, rst_ni, stalled |=> $stable(m_axis_tdata), "held data changed")

  // A stalled output stops intake so that no item is lost in the pipeline.
  `URSS_ASSERT(a_stall_blocks, clk_i, rst_ni, stalled |-> !s_axis_tready, "input taken in stall")

  // The distance never leaves its clamped range.
  `URSS_ASSERT_NEVER(a_dist_range, clk_i, rst_ni, m_axis_tvalid && over_max, "distance over range")

  // No echo reads as 9999, with a nine in both outer digits.
  `URSS_ASSERT(a_no_echo_nines, clk_i, rst_ni, out_none |-> shows_nines, "no-echo digits wrong")

endmodule

bind ultrasonic_range_to_seven_segment urss_checker u_urss_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
